// ===== hw/rtl/kspm_pkg.sv =====
// ----------------------------------------------------------------------------
// kspm_pkg
// Shared constants, codes and types for the key sequence prefix matcher.
// ----------------------------------------------------------------------------
package kspm_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int MAX_KEYS    = 4;
    localparam int TOOL_BITS   = 10;
    localparam int KEY_W       = 32;

    localparam int ENTRY_AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ENTRY_CW = $clog2(NUM_ENTRIES + 1);
    localparam int POS_AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    localparam logic [KEY_W-1:0] KEY_ESCAPE     = 32'h0000_FF1B;
    localparam logic [KEY_W-1:0] KEY_CTRL_LEFT  = 32'h0000_FFE3;
    localparam logic [KEY_W-1:0] KEY_SHIFT_LEFT = 32'h0000_FFE1;

    typedef enum logic [1:0] {
        ACT_PRESS = 2'd0,
        ACT_KEY   = 2'd1,
        ACT_ENTRY = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_WRITTEN  = 3'd0,
        ST_ESCAPE   = 3'd1,
        ST_MODIFIER = 3'd2,
        ST_PENDING  = 3'd3,
        ST_MATCHED  = 3'd4,
        ST_UNKNOWN  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef logic [MAX_KEYS-1:0][KEY_W-1:0] key_vec_t;

    typedef struct packed {
        key_vec_t               keys;
        logic [TOOL_BITS-1:0]   tool;
    } table_row_t;

    typedef struct packed {
        logic                   key_en;
        logic                   entry_en;
        logic [ENTRY_AW-1:0]    addr;
        logic [POS_AW-1:0]      pos;
        logic [KEY_W-1:0]       key;
        logic [CNT_W-1:0]       len;
        logic [TOOL_BITS-1:0]   tool;
    } table_wr_t;

    typedef struct packed {
        logic agree;
        logic exact;
    } cmp_res_t;

endpackage

// ===== hw/rtl/key_sequence_prefix_matcher.sv =====
// ----------------------------------------------------------------------------
// key_sequence_prefix_matcher
// Table writes, escape, modifiers and full-buffer keys go straight to emit; a
// scanned key press reads rows in order, each compare overlaps the next read,
// until an exact match or the last entry, then emits. Emit loads the output
// register once out_free. One transaction at a time; the next is taken the
// cycle after the result loads. Reset clears held count, table lengths.
// ----------------------------------------------------------------------------
module key_sequence_prefix_matcher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [31:0]         key,
    input  logic [3:0]          entry_index,
    input  logic [1:0]          key_position,
    input  logic [2:0]          entry_length,
    input  logic [9:0]          tool,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [9:0]          tool_out,
    output logic [2:0]          keys_held
);

    kspm_pkg::state_t                   state_reg, state_next;
    kspm_pkg::key_vec_t                 held_keys_reg, held_keys_next;
    logic [kspm_pkg::CNT_W-1:0]         held_cnt_reg, held_cnt_next;
    logic [kspm_pkg::ENTRY_CW-1:0]      issue_cnt_reg, issue_cnt_next;
    logic [kspm_pkg::ENTRY_CW-1:0]      eval_idx_reg, eval_idx_next;
    logic                               eval_vld_reg, eval_vld_next;
    logic                               pending_reg, pending_next;
    kspm_pkg::status_t                  res_status_reg, res_status_next;
    logic [kspm_pkg::TOOL_BITS-1:0]     res_tool_reg, res_tool_next;
    logic                               out_valid_reg, out_valid_next;
    kspm_pkg::status_t                  out_status_reg, out_status_next;
    logic [kspm_pkg::TOOL_BITS-1:0]     out_tool_reg, out_tool_next;
    logic [kspm_pkg::CNT_W-1:0]         out_held_reg, out_held_next;

    kspm_pkg::table_wr_t                tbl_wr;
    logic                               rd_en;
    logic [kspm_pkg::ENTRY_AW-1:0]      rd_addr;
    kspm_pkg::table_row_t               rd_row;
    logic [kspm_pkg::CNT_W-1:0]         rd_len;
    kspm_pkg::cmp_res_t                 cmp;

    logic                               accept;
    logic                               is_press;
    logic                               is_escape;
    logic                               is_modifier;
    logic                               is_full;
    logic                               out_free;
    logic                               last_entry;
    logic                               idx_ok;
    logic                               pos_ok;

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != kspm_pkg::S_IDLE);
    assign is_press    = (action == kspm_pkg::ACT_PRESS);
    assign is_escape   = (key == kspm_pkg::KEY_ESCAPE);
    assign is_modifier = (key == kspm_pkg::KEY_CTRL_LEFT) ||
                         (key == kspm_pkg::KEY_SHIFT_LEFT);
    assign is_full     = (32'(held_cnt_reg) >= kspm_pkg::MAX_KEYS);
    assign out_free    = !out_valid_reg || !out_stall;
    assign last_entry  = (eval_idx_reg == kspm_pkg::ENTRY_CW'(kspm_pkg::NUM_ENTRIES - 1));
    assign idx_ok      = (32'(entry_index) < kspm_pkg::NUM_ENTRIES);
    assign pos_ok      = (32'(key_position) < kspm_pkg::MAX_KEYS);

    // table writes happen only on accept in idle; scans never overlap them
    always_comb
    begin
        tbl_wr.key_en   = accept && (action == kspm_pkg::ACT_KEY) && idx_ok && pos_ok;
        tbl_wr.entry_en = accept && (action == kspm_pkg::ACT_ENTRY) && idx_ok;
        tbl_wr.addr     = kspm_pkg::ENTRY_AW'(entry_index);
        tbl_wr.pos      = kspm_pkg::POS_AW'(key_position);
        tbl_wr.key      = key;
        tbl_wr.len      = (32'(entry_length) > kspm_pkg::MAX_KEYS) ?
                          kspm_pkg::CNT_W'(kspm_pkg::MAX_KEYS) :
                          kspm_pkg::CNT_W'(entry_length);
        tbl_wr.tool     = kspm_pkg::TOOL_BITS'(tool);
    end

    assign rd_en   = (state_reg == kspm_pkg::S_SCAN) &&
                     (32'(issue_cnt_reg) < kspm_pkg::NUM_ENTRIES);
    assign rd_addr = kspm_pkg::ENTRY_AW'(issue_cnt_reg);

    kspm_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_row  (rd_row),
        .rd_len  (rd_len)
    );

    kspm_cmp u_cmp (
        .row_keys  (rd_row.keys),
        .row_len   (rd_len),
        .held_keys (held_keys_reg),
        .held_cnt  (held_cnt_reg),
        .res       (cmp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kspm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (is_press && !is_escape && !is_modifier && !is_full)
                    begin
                        state_next = kspm_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = kspm_pkg::S_EMIT;
                    end
                end
            end
            kspm_pkg::S_SCAN:
            begin
                if (eval_vld_reg && (cmp.exact || last_entry))
                begin
                    state_next = kspm_pkg::S_EMIT;
                end
            end
            kspm_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = kspm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kspm_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        held_keys_next  = held_keys_reg;
        held_cnt_next   = held_cnt_reg;
        issue_cnt_next  = issue_cnt_reg;
        eval_idx_next   = eval_idx_reg;
        eval_vld_next   = 1'b0;
        pending_next    = pending_reg;
        res_status_next = res_status_reg;
        res_tool_next   = res_tool_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_tool_next   = out_tool_reg;
        out_held_next   = out_held_reg;

        case (state_reg)
            kspm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = kspm_pkg::ST_WRITTEN;
                    res_tool_next   = '0;
                    if (is_press)
                    begin
                        if (is_escape)
                        begin
                            held_cnt_next   = '0;
                            res_status_next = kspm_pkg::ST_ESCAPE;
                        end
                        else if (is_modifier)
                        begin
                            res_status_next = kspm_pkg::ST_MODIFIER;
                        end
                        else if (is_full)
                        begin
                            held_cnt_next   = '0;
                            res_status_next = kspm_pkg::ST_UNKNOWN;
                        end
                        else
                        begin
                            held_keys_next[held_cnt_reg[kspm_pkg::POS_AW-1:0]] = key;
                            held_cnt_next  = held_cnt_reg + 1'b1;
                            issue_cnt_next = '0;
                            pending_next   = 1'b0;
                        end
                    end
                end
            end
            kspm_pkg::S_SCAN:
            begin
                // read of entry N overlaps compare of entry N-1
                if (rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    eval_vld_next  = 1'b1;
                    eval_idx_next  = issue_cnt_reg;
                end
                if (eval_vld_reg)
                begin
                    if (cmp.exact)
                    begin
                        eval_vld_next   = 1'b0;
                        held_cnt_next   = '0;
                        res_status_next = kspm_pkg::ST_MATCHED;
                        res_tool_next   = rd_row.tool;
                    end
                    else
                    begin
                        if (cmp.agree)
                        begin
                            pending_next = 1'b1;
                        end
                        if (last_entry)
                        begin
                            eval_vld_next = 1'b0;
                            if (pending_reg || cmp.agree)
                            begin
                                res_status_next = kspm_pkg::ST_PENDING;
                            end
                            else
                            begin
                                held_cnt_next   = '0;
                                res_status_next = kspm_pkg::ST_UNKNOWN;
                            end
                        end
                    end
                end
            end
            kspm_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_tool_next   = res_tool_reg;
                    out_held_next   = held_cnt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kspm_pkg::S_IDLE;
            held_cnt_reg  <= '0;
            eval_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_cnt_reg  <= held_cnt_next;
            eval_vld_reg  <= eval_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_keys_reg  <= held_keys_next;
        issue_cnt_reg  <= issue_cnt_next;
        eval_idx_reg   <= eval_idx_next;
        pending_reg    <= pending_next;
        res_status_reg <= res_status_next;
        res_tool_reg   <= res_tool_next;
        out_status_reg <= out_status_next;
        out_tool_reg   <= out_tool_next;
        out_held_reg   <= out_held_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign tool_out  = 10'(out_tool_reg);
    assign keys_held = 3'(out_held_reg);

endmodule

// ===== hw/rtl/kspm_table.sv =====
// ----------------------------------------------------------------------------
// kspm_table
// Sequence table: one row per entry (keys and tool) in a synchronous memory,
// entry lengths in reset flops. One row read per cycle, data registered.
// ----------------------------------------------------------------------------
module kspm_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kspm_pkg::table_wr_t                 wr,
    input  logic                                rd_en,
    input  logic [kspm_pkg::ENTRY_AW-1:0]       rd_addr,
    output kspm_pkg::table_row_t                rd_row,
    output logic [kspm_pkg::CNT_W-1:0]          rd_len
);

    kspm_pkg::table_row_t               mem [kspm_pkg::NUM_ENTRIES];
    logic [kspm_pkg::CNT_W-1:0]         len_reg [kspm_pkg::NUM_ENTRIES];
    kspm_pkg::table_row_t               rd_row_reg;
    logic [kspm_pkg::CNT_W-1:0]         rd_len_reg;

    always_ff @(posedge clk)
    begin
        if (wr.key_en)
        begin
            mem[wr.addr].keys[wr.pos] <= wr.key;
        end
        if (wr.entry_en)
        begin
            mem[wr.addr].tool <= wr.tool;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
            rd_len_reg <= len_reg[rd_addr];
        end
    end

    // length zero marks an unused entry, so lengths are cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kspm_pkg::NUM_ENTRIES; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (wr.entry_en)
        begin
            len_reg[wr.addr] <= wr.len;
        end
    end

    assign rd_row = rd_row_reg;
    assign rd_len = rd_len_reg;

endmodule

// ===== hw/rtl/kspm_cmp.sv =====
// ----------------------------------------------------------------------------
// kspm_cmp
// Compares one table row against the held keys over the shorter length.
// ----------------------------------------------------------------------------
module kspm_cmp (
    input  kspm_pkg::key_vec_t                  row_keys,
    input  logic [kspm_pkg::CNT_W-1:0]          row_len,
    input  kspm_pkg::key_vec_t                  held_keys,
    input  logic [kspm_pkg::CNT_W-1:0]          held_cnt,
    output kspm_pkg::cmp_res_t                  res
);

    logic [kspm_pkg::MAX_KEYS-1:0] lane_ok;
    logic                          used;

    always_comb
    begin
        for (int i = 0; i < kspm_pkg::MAX_KEYS; i++)
        begin
            // lanes beyond either length do not take part
            lane_ok[i] = (row_keys[i] == held_keys[i]) ||
                         (32'(row_len) <= i) || (32'(held_cnt) <= i);
        end
    end

    assign used      = (row_len != '0);
    assign res.agree = used && (&lane_ok);
    assign res.exact = used && (&lane_ok) && (row_len == held_cnt);

endmodule
